### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic Hermite patch package
// Shared widths, codes, sequencer types and helper functions.
// ----------------------------------------------------------------------------
package bhp_pkg;

	// Data width and internal accumulator width.
	localparam int DW = 48;
	localparam int AW = 56;

	// Function codes carried in the input tuser.
	localparam logic [1:0] FUNC_LOAD     = 2'd0;
	localparam logic [1:0] FUNC_EVAL     = 2'd1;
	localparam logic [1:0] FUNC_RESTRICT = 2'd2;

	// Result kinds carried in the output tuser.
	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_COEF = 1'b1;

	localparam logic signed [AW-1:0] SAT_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_MIN = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_EVAL  = 5'b00100,
		ST_RESTR = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// One step of the shared unit: res = m * x + round(p * c).
	typedef struct packed {
		logic signed [2:0] m;
		logic              zero_p;
	} mac_op_t;

	// Inverse Hermite Vandermonde matrix entry.
	function automatic logic signed [2:0] hinv(input logic [1:0] r, input logic [1:0] c);
		logic signed [2:0] v;
		case ({r, c})
			4'b0000: v = 3'sd1;
			4'b0110: v = 3'sd1;
			4'b1000: v = -3'sd3;
			4'b1001: v = 3'sd3;
			4'b1010: v = -3'sd2;
			4'b1011: v = -3'sd1;
			4'b1100: v = 3'sd2;
			4'b1101: v = -3'sd2;
			4'b1110: v = 3'sd1;
			4'b1111: v = 3'sd1;
			default: v = 3'sd0;
		endcase
		return v;
	endfunction

	// Saturate an accumulator value to the data width.
	function automatic logic [DW-1:0] sat_dw(input logic signed [AW-1:0] v);
		logic [DW-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DW-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DW-1:0];
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

	// Sign-extend a datum to the accumulator width.
	function automatic logic signed [AW-1:0] sext_dw(input logic [DW-1:0] x);
		return {{(AW-DW){x[DW-1]}}, x};
	endfunction

endpackage

### rtl/bhp_mac.sv
// ----------------------------------------------------------------------------
// Bicubic Hermite patch shared arithmetic unit
// Computes m * x + round(p * c / 2^(CW-1)) for one sequencer step.
// ----------------------------------------------------------------------------
module bhp_mac import bhp_pkg::*; #(
	parameter int CW = 17
) (
	input  mac_op_t                 op,
	input  logic signed [AW-1:0]    x,
	input  logic signed [AW-1:0]    p,
	input  logic        [CW-1:0]    c,
	output logic signed [AW-1:0]    res
);

	localparam int PW = AW + CW + 1;

	logic signed [PW-1:0] p_ext;
	logic signed [PW-1:0] c_ext;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic signed [AW+2:0] mx;

	// Rounded product of the running value by the coordinate.
	always_comb begin
		p_ext = op.zero_p ? '0 : PW'(p);
		c_ext = PW'($signed({1'b0, c}));
		prod  = p_ext * c_ext;
		rnd   = (prod + (PW'(1) <<< (CW-2))) >>> (CW-1);
	end

	// Small constant times the new term, then the sum.
	always_comb begin
		mx  = (AW+3)'(x) * (AW+3)'(op.m);
		res = rnd[AW-1:0] + mx[AW-1:0];
	end

endmodule

### rtl/bicubic_hermite_patch_top.sv
// ----------------------------------------------------------------------------
// Bicubic Hermite patch, top level
// Stores corner data and patch coefficients, evaluates and restricts the patch.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ group; s_tuser selects load, evaluate or
// restrict. The block takes one item at a time and drops s_tready until
// its sequencer is idle again. All arithmetic runs through one shared
// multiply-add unit stepped by a counter, one term per cycle.
// A load writes one corner datum and recomputes all sixteen coefficients
// (two 4x4x4 products); it has no result, and the next item can be taken
// once both products are done.
// An evaluate runs six Horner passes of seven steps; its one result has
// m_tlast high, and the next item can be taken once that result has been
// loaded into the output register.
// A restrict runs four sums of four terms; its four results follow one
// per cycle while the receiver does not stall, m_tlast on the fourth, and
// the next item can be taken once the fourth is in the output register.
// Results leave through one output register. The sequencer waits while
// that register is full and the receiver stalls, so s_tready stays low
// until the last result of the item has been loaded into it.
// Reset clears the corner data and the coefficients to zero and the output
// register to empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bicubic_hermite_patch_top import bhp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// row, col, data_value, lam_coord, mu_coord, edge_var, edge_side, zero fill
	input  logic [((54 + 2*(COORD_FRAC_BITS+1) + 7) / 8) * 8 - 1:0] s_tdata,
	// func
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// f_value, dlam_value, dmu_value, dlammu_value, coef_index, coef_value, zero fill
	output logic [247:0]  m_tdata,
	// kind
	output logic [0:0]    m_tuser,
	output logic          m_tlast
);

	localparam int CW  = COORD_FRAC_BITS + 1;
	localparam int LAM = 52;
	localparam int MU  = LAM + CW;
	localparam int EV  = MU + CW;
	localparam int ES  = EV + 1;
	localparam logic [CW-1:0] ONE = CW'(1) << (CW-1);

	state_t state_q;
	logic [6:0]      cnt_q;
	logic [1:0]      out_idx_q;
	logic            m_tvalid_q;
	logic [DW-1:0]   corner_q [16];
	logic [DW-1:0]   coef_q [16];
	logic signed [AW-1:0] tmp_q [16];
	logic signed [AW-1:0] g_q [4];
	logic signed [AW-1:0] gp_q [4];
	logic signed [AW-1:0] res_q [4];
	logic signed [AW-1:0] acc_q;
	logic [CW-1:0]   lam_q;
	logic [CW-1:0]   mu_q;
	logic            along_q;
	logic            far_q;
	logic            restr_q;
	logic [247:0]    m_tdata_q;
	logic            m_tuser_q;
	logic            m_tlast_q;

	logic            accept;
	logic            emit_load;
	logic [CW-1:0]   lam_in;
	logic [CW-1:0]   mu_in;
	mac_op_t         op;
	logic signed [AW-1:0] x;
	logic [CW-1:0]   c;
	logic signed [AW-1:0] res;
	logic [1:0]      k;

	// Handshake strobes.
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign emit_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	// Coordinates above one are taken as one.
	assign lam_in = (s_tdata[MU-1:LAM] > ONE) ? ONE : s_tdata[MU-1:LAM];
	assign mu_in  = (s_tdata[EV-1:MU] > ONE) ? ONE : s_tdata[EV-1:MU];

	// Step decode: operand, constant and coordinate for the shared unit.
	always_comb begin
		op = '0;
		x  = '0;
		c  = ONE;
		k  = cnt_q[1:0];
		case (state_q)
			ST_LOAD: begin
				op.zero_p = (cnt_q[1:0] == 2'd0);
				if (!cnt_q[6]) begin
					x    = sext_dw(corner_q[{cnt_q[1:0], cnt_q[3:2]}]);
					op.m = hinv(cnt_q[5:4], cnt_q[1:0]);
				end else begin
					x    = tmp_q[{cnt_q[5:4], cnt_q[1:0]}];
					op.m = hinv(cnt_q[3:2], cnt_q[1:0]);
				end
			end
			ST_EVAL: begin
				case (cnt_q[2:0])
					3'd0: begin k = 2'd3; op.m = 3'sd1; op.zero_p = 1'b1; end
					3'd1: begin k = 2'd2; op.m = 3'sd1; end
					3'd2: begin k = 2'd1; op.m = 3'sd1; end
					3'd3: begin k = 2'd0; op.m = 3'sd1; end
					3'd4: begin k = 2'd3; op.m = 3'sd3; op.zero_p = 1'b1; end
					3'd5: begin k = 2'd2; op.m = 3'sd2; end
					3'd6: begin k = 2'd1; op.m = 3'sd1; end
					default: begin k = 2'd0; op.m = 3'sd0; end
				endcase
				if (!cnt_q[6]) begin
					x = sext_dw(coef_q[{cnt_q[5:4], k}]);
					c = mu_q;
				end else begin
					x = cnt_q[4] ? gp_q[k] : g_q[k];
					c = lam_q;
				end
			end
			ST_RESTR: begin
				op.zero_p = (cnt_q[1:0] == 2'd0);
				op.m      = (far_q || cnt_q[1:0] == 2'd0) ? 3'sd1 : 3'sd0;
				x = along_q ? sext_dw(coef_q[{cnt_q[1:0], cnt_q[3:2]}])
				            : sext_dw(coef_q[{cnt_q[3:2], cnt_q[1:0]}]);
			end
			default: begin
				op = '0;
			end
		endcase
	end

	bhp_mac #(.CW(CW)) u_mac (
		.op  (op),
		.x   (x),
		.p   (acc_q),
		.c   (c),
		.res (res)
	);

	// Sequencer, stored data and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			out_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
			for (int n = 0; n < 16; n++) begin
				corner_q[n] <= '0;
				coef_q[n]   <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready && !emit_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					out_idx_q <= '0;
					if (accept) begin
						case (s_tuser)
							FUNC_LOAD: begin
								corner_q[{s_tdata[1:0], s_tdata[3:2]}] <= s_tdata[51:4];
								state_q <= ST_LOAD;
							end
							FUNC_EVAL:     state_q <= ST_EVAL;
							FUNC_RESTRICT: state_q <= ST_RESTR;
							default:       state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD: begin
					if (cnt_q[6] && cnt_q[1:0] == 2'd3) begin
						coef_q[cnt_q[5:2]] <= sat_dw(res);
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EVAL: begin
					if (cnt_q[2:0] == 3'd6) begin
						cnt_q <= {cnt_q[6:4] + 3'd1, 4'd0};
						if (cnt_q[6:4] == 3'd5) begin
							state_q <= ST_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_RESTR: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[3:0] == 4'd15) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						m_tvalid_q <= 1'b1;
						out_idx_q  <= out_idx_q + 2'd1;
						if (!restr_q || out_idx_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			lam_q   <= lam_in;
			mu_q    <= mu_in;
			along_q <= s_tdata[EV];
			far_q   <= s_tdata[ES];
			restr_q <= (s_tuser == FUNC_RESTRICT);
		end
		if (state_q != ST_IDLE && state_q != ST_EMIT) begin
			acc_q <= res;
		end
		if (state_q == ST_LOAD && !cnt_q[6] && cnt_q[1:0] == 2'd3) begin
			tmp_q[cnt_q[5:2]] <= res;
		end
		if (state_q == ST_EVAL) begin
			if (cnt_q[2:0] == 3'd3) begin
				if (!cnt_q[6]) g_q[cnt_q[5:4]] <= res;
				else res_q[{cnt_q[4], 1'b0}] <= res;
			end
			if (cnt_q[2:0] == 3'd6) begin
				if (!cnt_q[6]) gp_q[cnt_q[5:4]] <= res;
				else res_q[{cnt_q[4], 1'b1}] <= res;
			end
		end
		if (state_q == ST_RESTR && cnt_q[1:0] == 2'd3) begin
			res_q[cnt_q[3:2]] <= res;
		end
		if (emit_load) begin
			if (!restr_q) begin
				m_tdata_q <= {6'd0, {DW{1'b0}}, 2'd0, sat_dw(res_q[3]), sat_dw(res_q[2]),
				              sat_dw(res_q[1]), sat_dw(res_q[0])};
				m_tuser_q <= KIND_EVAL;
				m_tlast_q <= 1'b1;
			end else begin
				m_tdata_q <= {6'd0, sat_dw(res_q[out_idx_q]), out_idx_q, {(4*DW){1'b0}}};
				m_tuser_q <= KIND_COEF;
				m_tlast_q <= (out_idx_q == 2'd3);
			end
		end
	end

	// Checks on sequencing and result framing.
	`ASSERT_IMPL(a_eval_is_last, clk, arst_n, m_tvalid && m_tuser[0] == KIND_EVAL, m_tlast)
	`ASSERT_NEXT(a_eval_starts, clk, arst_n, accept && s_tuser == FUNC_EVAL, state_q == ST_EVAL)
	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q == ST_LOAD || state_q == ST_EMIT, !s_tready)

endmodule

### verif/bicubic_hermite_patch_top_tb.sv
// ----------------------------------------------------------------------------
// Bicubic Hermite patch testbench
// Drives load, evaluate, restrict and unused-code items with random handshake
// gaps and checks every result field against a behavioral model of the patch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bicubic_hermite_patch_top_tb import bhp_pkg::*; ();

	localparam int CFB = 16;
	localparam int SW = ((54 + 2*(CFB+1) + 7) / 8) * 8;
	localparam longint W48_MAX = (64'sd1 <<< 47) - 1;
	localparam longint W48_MIN = -(64'sd1 <<< 47);

	typedef struct {
		logic        kind;
		logic [47:0] f, dl, dm, dlm;
		logic [1:0]  idx;
		logic [47:0] coef;
		logic        last;
	} patch_out_t;

	typedef struct {
		logic [1:0]  func;
		logic [1:0]  row, col;
		logic [47:0] datum;
		logic [16:0] lam, mu;
		logic        evar, eside;
		bit          fixed;      // expected coefficient typed in below
		logic [47:0] fixed_coef; // coefficient zero of a restrict
	} patch_item_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [247:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;

	bicubic_hermite_patch_top #(.COORD_FRAC_BITS(CFB)) u_top (.*);

	always #10 clk = ~clk;

	// Model state: corner data and patch coefficients.
	longint corner_d[16];
	longint coef_a[16];
	patch_out_t pending_results[$];
	int errors = 0;
	bit hold_off = 0;
	int hold_cycles = 0;
	bit stim_done = 0;

	function automatic longint sat48(longint v);
		if (v > W48_MAX) return W48_MAX;
		if (v < W48_MIN) return W48_MIN;
		return v;
	endfunction

	// Rounded product by a Q1.16 coordinate, floor((x*c + half) >> 16).
	function automatic longint cmul(longint x, longint c);
		longint lo, hi;
		lo = x & ((64'sd1 <<< CFB) - 1);
		hi = (x - lo) >>> CFB;
		return hi * c + ((lo * c + (64'sd1 <<< (CFB - 1))) >>> CFB);
	endfunction

	function automatic int hinv_m(int r, int c);
		int m[4][4] = '{'{1, 0, 0, 0}, '{0, 0, 1, 0}, '{-3, 3, -2, -1}, '{2, -2, 1, 1}};
		return m[r][c];
	endfunction

	function automatic void rebuild_coefs();
		longint t[4][4];
		longint s;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				s = 0;
				for (int k = 0; k < 4; k++) s += hinv_m(i, k) * corner_d[k*4+j];
				t[i][j] = s;
			end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				s = 0;
				for (int k = 0; k < 4; k++) s += t[i][k] * hinv_m(j, k);
				coef_a[i*4+j] = sat48(s);
			end
	endfunction

	// Apply one accepted item to the model and queue its results.
	function automatic void predict_patch(patch_item_t it);
		longint lam, mu, g[4], gp[4], s;
		patch_out_t r;
		r = '{default: '0};
		case (it.func)
			FUNC_LOAD: begin
				corner_d[{it.row, it.col}] = longint'($signed(it.datum));
				rebuild_coefs();
			end
			FUNC_EVAL: begin
				lam = (it.lam > 17'h10000) ? 65536 : it.lam;
				mu = (it.mu > 17'h10000) ? 65536 : it.mu;
				for (int i = 0; i < 4; i++) begin
					g[i] = coef_a[i*4] + cmul(coef_a[i*4+1] + cmul(coef_a[i*4+2]
						+ cmul(coef_a[i*4+3], mu), mu), mu);
					gp[i] = coef_a[i*4+1] + cmul(2*coef_a[i*4+2] + cmul(3*coef_a[i*4+3], mu), mu);
				end
				r.kind = KIND_EVAL;
				r.f = 48'(sat48(g[0] + cmul(g[1] + cmul(g[2] + cmul(g[3], lam), lam), lam)));
				r.dl = 48'(sat48(g[1] + cmul(2*g[2] + cmul(3*g[3], lam), lam)));
				r.dm = 48'(sat48(gp[0] + cmul(gp[1] + cmul(gp[2] + cmul(gp[3], lam), lam),
					lam)));
				r.dlm = 48'(sat48(gp[1] + cmul(2*gp[2] + cmul(3*gp[3], lam), lam)));
				r.last = 1;
				pending_results.push_back(r);
			end
			FUNC_RESTRICT: begin
				for (int i = 0; i < 4; i++) begin
					s = 0;
					if (!it.eside) s = it.evar ? coef_a[i] : coef_a[i*4];
					else for (int k = 0; k < 4; k++)
						s += it.evar ? coef_a[k*4+i] : coef_a[i*4+k];
					r = '{default: '0};
					r.kind = KIND_COEF;
					r.idx = 2'(i);
					r.coef = 48'(sat48(s));
					if (i == 0 && it.fixed) r.coef = it.fixed_coef;
					r.last = (i == 3);
					pending_results.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [47:0] rand48();
		case ($urandom_range(0, 5))
			0: return 48'h7FFF_FFFF_FFFF;
			1: return 48'h8000_0000_0000;
			2: return 48'({$urandom, $urandom} & 64'h0000_0000_0FFF_FFFF);
			3: return 48'(-({$urandom, $urandom} & 64'h0000_0000_0FFF_FFFF));
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [16:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 17'h10000;
			1: return 17'h0;
			2: return 17'h10000 + 17'($urandom_range(1, 65535));
			default: return 17'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic patch_item_t rand_item();
		patch_item_t it;
		int p;
		it = '{default: '0};
		p = $urandom_range(0, 99);
		it.func = (p < 45) ? FUNC_LOAD : (p < 75) ? FUNC_EVAL : (p < 97) ? FUNC_RESTRICT : 2'd3;
		it.row = 2'($urandom);
		it.col = 2'($urandom);
		it.datum = rand48();
		it.lam = rand_coord();
		it.mu = rand_coord();
		it.evar = 1'($urandom);
		it.eside = 1'($urandom);
		return it;
	endfunction

	// Send one item; gaps before, model updated at the transfer.
	task automatic send_item(patch_item_t it);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {it.eside, it.evar, it.mu, it.lam, it.datum, it.col, it.row};
		s_tuser <= it.func;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		predict_patch(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic patch_item_t mk(logic [1:0] f, logic [1:0] r, logic [1:0] c,
			logic [47:0] d, logic [16:0] l, logic [16:0] m, logic ev, logic es);
		patch_item_t it;
		it = '{default: '0};
		it.func = f; it.row = r; it.col = c; it.datum = d;
		it.lam = l; it.mu = m; it.evar = ev; it.eside = es;
		return it;
	endfunction

	// Directed table, then random items.
	initial begin
		patch_item_t dir[$];
		patch_item_t it;
		for (int i = 0; i < 16; i++) begin corner_d[i] = 0; coef_a[i] = 0; end
		// Restrict right after reset gives zero coefficients.
		it = mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 0, 0); it.fixed = 1; it.fixed_coef = '0;
		dir.push_back(it);
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 17'h10000, 17'h10000, 0, 0));
		dir.push_back(mk(FUNC_LOAD, 0, 0, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0));
		// Coefficient zero on the near edge equals the f0,f0 datum.
		it = mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 0, 0); it.fixed = 1;
		it.fixed_coef = 48'h7FFF_FFFF_FFFF;
		dir.push_back(it);
		dir.push_back(mk(FUNC_LOAD, 1, 1, 48'h8000_0000_0000, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_LOAD, 2, 3, 48'h0000_0100_0000, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_LOAD, 3, 2, 48'hFFFF_FF00_0000, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 17'h10000, 0, 0, 0));
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 17'h1FFFF, 17'h1FFFF, 0, 0));
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 17'h08000, 17'h0FFFF, 0, 0));
		dir.push_back(mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 0, 1));
		dir.push_back(mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 1, 0));
		dir.push_back(mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 1, 1));
		dir.push_back(mk(2'd3, 3, 3, 48'hFFFF_FFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 1, 1));
		dir.push_back(mk(FUNC_LOAD, 3, 3, 48'h5555_5555_5555, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_LOAD, 0, 3, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0));
		dir.push_back(mk(FUNC_EVAL, 0, 0, 0, 17'h0AAAA, 17'h05555, 0, 0));
		dir.push_back(mk(FUNC_RESTRICT, 0, 0, 0, 0, 0, 1, 1));

		repeat (10) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);
		foreach (dir[i]) send_item(dir[i]);
		for (int n = 0; n < 350; n++) begin
			if (n == 100) wait_drained(); // sender pause until drained
			if (n == 200) begin
				hold_cycles = 600;
				hold_off = 1;
			end
			send_item(rand_item());
		end
		wait_drained();
		stim_done = 1;
	end

	// Receiver: random stalls, plus one long hold-off.
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 0;
				repeat (hold_cycles) @(negedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Result checker at the rising edge.
	always @(posedge clk) begin
		patch_out_t e;
		patch_out_t a;
		if (arst_n && m_tvalid && m_tready) begin
			a.f = m_tdata[47:0];
			a.dl = m_tdata[95:48];
			a.dm = m_tdata[143:96];
			a.dlm = m_tdata[191:144];
			a.idx = m_tdata[193:192];
			a.coef = m_tdata[241:194];
			a.kind = m_tuser[0];
			a.last = m_tlast;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result: kind %0d", a.kind);
			end else begin
				e = pending_results.pop_front();
				if (e.kind !== a.kind || e.f !== a.f || e.dl !== a.dl || e.dm !== a.dm
						|| e.dlm !== a.dlm || e.idx !== a.idx || e.coef !== a.coef
						|| e.last !== a.last || m_tdata[247:242] !== '0) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch expected k%0d f%h dl%h dm%h dlm%h i%0d c%h l%0d",
							e.kind, e.f, e.dl, e.dm, e.dlm, e.idx, e.coef, e.last);
						$display("         actual   k%0d f%h dl%h dm%h dlm%h i%0d c%h l%0d",
							a.kind, a.f, a.dl, a.dm, a.dlm, a.idx, a.coef, a.last);
					end
				end
			end
		end
	end

	// Final verdict.
	initial begin
		wait (stim_done);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
